// ===== hw/rtl/ffsi_pkg.sv =====
// shared constants, codes and distance helpers for the fuzzy fan speed block
`timescale 1ns / 1ps

package ffsi_pkg;

    // defaults for the top-level parameters
    localparam int SPEED_MAX_DEF   = 1500;
    localparam int DEGREE_BITS_DEF = 10;

    // input saturation limits
    localparam logic [6:0] TEMP_SAT    = 7'd120;
    localparam logic [6:0] WEATHER_SAT = 7'd100;

    // configuration
    localparam int          RULE_N         = 12;
    localparam int          RULE_MAP_W     = 2 * RULE_N;
    localparam logic [23:0] RULE_MAP_RESET = 24'hAA9510;
    localparam logic        REG_RULE_MAP   = 1'b0;

    // output set codes
    localparam logic [1:0] SET_SLOW   = 2'd0;
    localparam logic [1:0] SET_MEDIUM = 2'd1;
    localparam logic [1:0] SET_FAST   = 2'd2;
    localparam logic [1:0] SET_NONE   = 2'd3;

    // temperature breakpoints (all slopes span 20)
    localparam logic [6:0] T_BRK_A = 7'd30;
    localparam logic [6:0] T_BRK_B = 7'd50;
    localparam logic [6:0] T_BRK_C = 7'd70;
    localparam logic [6:0] T_BRK_D = 7'd90;
    localparam int         T_SPAN  = 20;

    // weather breakpoints
    localparam logic [6:0] W_RAIN_HI    = 7'd50;
    localparam int         W_RAIN_SPAN  = 30;
    localparam logic [6:0] W_CLOUD_LO   = 7'd40;
    localparam logic [6:0] W_CLOUD_PEAK = 7'd55;
    localparam logic [6:0] W_CLOUD_HI   = 7'd70;
    localparam int         W_CLOUD_SPAN = 15;
    localparam logic [6:0] W_CLEAR_LO   = 7'd60;
    localparam int         W_CLEAR_SPAN = 20;

    // output set breakpoints
    localparam int          XF_W        = 12;
    localparam logic [11:0] S_SLOW_HI   = 12'd500;
    localparam logic [11:0] S_MED_LO    = 12'd450;
    localparam logic [11:0] S_MED_PEAK  = 12'd950;
    localparam logic [11:0] S_MED_HI    = 12'd1050;
    localparam logic [11:0] S_FAST_LO   = 12'd900;
    localparam int          S_SET_SPAN  = 100;
    localparam int          S_FAST_SPAN = 200;

    // fuzzification sweep covers every distance up to the widest input span
    localparam logic [4:0] FUZZ_LAST = 5'd30;

    // clamped distance into a rising input slope
    function automatic logic [4:0] in_rise(logic [6:0] v, logic [6:0] lo, logic [4:0] span);
        logic [6:0] diff;
        diff = v - lo;
        if (v <= lo)
            return 5'd0;
        else if (diff >= {2'b00, span})
            return span;
        else
            return diff[4:0];
    endfunction

    // clamped distance into a falling input slope
    function automatic logic [4:0] in_fall(logic [6:0] v, logic [6:0] hi, logic [4:0] span);
        logic [6:0] diff;
        diff = hi - v;
        if (v >= hi)
            return 5'd0;
        else if (diff >= {2'b00, span})
            return span;
        else
            return diff[4:0];
    endfunction

    // clamped distance into a rising output slope
    function automatic logic [7:0] out_rise(logic [11:0] x, logic [11:0] lo, logic [7:0] span);
        logic [11:0] diff;
        diff = x - lo;
        if (x <= lo)
            return 8'd0;
        else if (diff >= {4'b0000, span})
            return span;
        else
            return diff[7:0];
    endfunction

    // clamped distance into a falling output slope
    function automatic logic [7:0] out_fall(logic [11:0] x, logic [11:0] hi, logic [7:0] span);
        logic [11:0] diff;
        diff = hi - x;
        if (x >= hi)
            return 8'd0;
        else if (diff >= {4'b0000, span})
            return span;
        else
            return diff[7:0];
    endfunction

    // distances of the three output sets at a speed point
    function automatic logic [7:0] set_dist(logic [1:0] set, logic [11:0] x);
        case (set)
            SET_SLOW:   return out_fall(x, S_SLOW_HI, 8'(S_SET_SPAN));
            SET_MEDIUM: return (x <= S_MED_PEAK) ? out_rise(x, S_MED_LO, 8'(S_SET_SPAN))
                                                 : out_fall(x, S_MED_HI, 8'(S_SET_SPAN));
            SET_FAST:   return out_rise(x, S_FAST_LO, 8'(S_FAST_SPAN));
            default:    return 8'd0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/ffsi_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module ffsi_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1501
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/fuzzy_fan_speed_inference.sv =====
// fuzzy fan speed inference: fuzzify, rule map, centroid walk, divider
`timescale 1ns / 1ps

// usage
// - sample channel (valid/ready) carries temperature and weather; values above
//   120 and 100 are saturated; one result item follows each sample item
// - result channel (valid/ready) carries speed_integer, speed_fraction (sixteenths),
//   speed_class and no_output; the result sits in an output register
// - apb-style port holds rule_map at byte address 0; write it only while idle
// - an item passes from accept to the next accept through fuzzification, rule
//   evaluation, a walk of the speed points on the class memory write port, a
//   drain of the weighted sum pipeline, the divider (one bit of the shifted
//   numerator per cycle) and one memory read
// - an empty output curve skips the divider and the read
// - the speed point walk dominates, one output point per clock
// - sample_ready is high only while no item is in flight; a new item may be
//   taken while the previous result still waits in the output register
// - if the receiver stalls, the finished item waits in its last state until the
//   output register frees up
// - reset returns to idle, drops result_valid and restores the reset rule map;
//   the class memory needs no clearing as each walk writes every point it reads

module fuzzy_fan_speed_inference
    import ffsi_pkg::*;
#(
    parameter int SPEED_MAX   = SPEED_MAX_DEF,
    parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample channel
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic [6:0]                       temperature,
    input  logic [6:0]                       weather,
    // result channel
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [$clog2(SPEED_MAX+1)-1:0]   speed_integer,
    output logic [3:0]                       speed_fraction,
    output logic [1:0]                       speed_class,
    output logic                             no_output,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // widths
    localparam int  DEG_W   = DEGREE_BITS + 1;
    localparam int  ONE     = 1 << DEGREE_BITS;
    localparam int  X_W     = $clog2(SPEED_MAX + 1);
    localparam int  PROD_W  = X_W + DEG_W;
    localparam longint NUM_MAX = (longint'(SPEED_MAX) * longint'(SPEED_MAX + 1) / 2)
                                 * longint'(ONE);
    localparam int  NUM_W   = $clog2(NUM_MAX + 1);
    localparam int  DEN_W   = $clog2((SPEED_MAX + 1) * ONE + 1);
    localparam int  DIVD_W  = NUM_W + 4;
    localparam int  DC_W    = $clog2(DIVD_W);
    localparam int  Q_W     = X_W + 4;
    localparam int  R_W     = $clog2(2 * S_FAST_SPAN);
    localparam int  TR_N    = 6;
    localparam logic [DEG_W-1:0]  DEG_ONE  = {1'b1, {DEGREE_BITS{1'b0}}};
    localparam logic [X_W-1:0]    X_LAST   = X_W'(SPEED_MAX);
    localparam logic [DC_W-1:0]   DIV_LAST = DC_W'(DIVD_W - 1);

    // ramp trackers: three input slopes, then slow, medium, fast output sets
    localparam int TR_SPAN [TR_N] = '{W_CLOUD_SPAN, T_SPAN, W_RAIN_SPAN,
                                      S_SET_SPAN, S_SET_SPAN, S_FAST_SPAN};

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FUZZ  = 3'd1;
    localparam logic [2:0] S_RULE  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;
    localparam logic [2:0] S_CLS   = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [RULE_MAP_W-1:0] rule_map_reg;

    logic [6:0]            t_reg, w_reg;
    logic [4:0]            k_reg;
    logic [3:0]            rc_reg;
    logic [1:0]            ti_reg, wj_reg;
    logic [X_W-1:0]        x_reg;
    logic [DC_W-1:0]       dc_reg;
    logic                  v1_reg, v2_reg;
    logic                  den_zero_reg;

    logic [DEG_W-1:0]      td_reg [4];
    logic [DEG_W-1:0]      wd_reg [3];
    logic [DEG_W-1:0]      str_reg [3];
    logic [4:0]            dt [4];
    logic [4:0]            dw [3];

    // ramp tracker state: degree = round(d * ONE / span), kept as quotient and
    // remainder of (2 d ONE + span) / 2 span so each step of d is one add
    logic [DEG_W-1:0]      trk_q_reg [TR_N];
    logic [R_W-1:0]        trk_r_reg [TR_N];
    logic                  trk_init [TR_N];
    logic                  trk_up [TR_N];
    logic                  trk_dn [TR_N];
    logic [DEG_W-1:0]      trk_init_q [TR_N];

    logic [7:0]            od_reg [3];
    logic [7:0]            od_tgt [3];
    logic [7:0]            od_zero [3];
    logic [XF_W-1:0]       x_ahead;

    logic [DEG_W-1:0]      clip [3];
    logic [DEG_W-1:0]      agg;
    logic [1:0]            cls;
    logic [DEG_W-1:0]      agg1_reg, agg2_reg;
    logic [X_W-1:0]        xa_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DEN_W-1:0]      den_reg;

    logic [DIVD_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [Q_W-1:0]        quo_reg;
    logic [DEN_W:0]        rem_sh, rem_sub;
    logic                  rem_ge;

    logic [DEG_W-1:0]      rule_deg;
    logic [1:0]            rule_set;
    logic [1:0]            cls_rd;

    logic                  sample_acc, cfg_wr, res_free;

    assign sample_ready = (state_reg == S_IDLE);
    assign sample_acc   = sample_valid && sample_ready;
    assign res_free     = !result_valid || result_ready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_RULE_MAP) ? {8'd0, rule_map_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_map_reg <= RULE_MAP_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_RULE_MAP))
        begin
            rule_map_reg <= pwdata[RULE_MAP_W-1:0];
        end
    end

    // slope distances of the saturated inputs
    always_comb
    begin
        dt[0] = in_fall(t_reg, T_BRK_B, 5'(T_SPAN));
        dt[1] = (t_reg <= T_BRK_B) ? in_rise(t_reg, T_BRK_A, 5'(T_SPAN))
                                   : in_fall(t_reg, T_BRK_C, 5'(T_SPAN));
        dt[2] = (t_reg <= T_BRK_C) ? in_rise(t_reg, T_BRK_B, 5'(T_SPAN))
                                   : in_fall(t_reg, T_BRK_D, 5'(T_SPAN));
        dt[3] = in_rise(t_reg, T_BRK_C, 5'(T_SPAN));
        dw[0] = in_fall(w_reg, W_RAIN_HI, 5'(W_RAIN_SPAN));
        dw[1] = (w_reg <= W_CLOUD_PEAK) ? in_rise(w_reg, W_CLOUD_LO, 5'(W_CLOUD_SPAN))
                                        : in_fall(w_reg, W_CLOUD_HI, 5'(W_CLOUD_SPAN));
        dw[2] = in_rise(w_reg, W_CLEAR_LO, 5'(W_CLEAR_SPAN));
    end

    // output set distances one point ahead of the walk
    assign x_ahead = XF_W'(x_reg) + XF_W'(1);

    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            od_tgt[s]  = set_dist(2'(s), x_ahead);
            od_zero[s] = set_dist(2'(s), '0);
        end
    end

    // tracker control
    always_comb
    begin
        for (int g = 0; g < 3; g++)
        begin
            trk_init[g]   = (state_reg == S_IDLE);
            trk_up[g]     = (state_reg == S_FUZZ);
            trk_dn[g]     = 1'b0;
            trk_init_q[g] = '0;
        end
        for (int s = 0; s < 3; s++)
        begin
            trk_init[3+s]   = (state_reg != S_WALK);
            trk_up[3+s]     = (state_reg == S_WALK) && (od_tgt[s] > od_reg[s]);
            trk_dn[3+s]     = (state_reg == S_WALK) && (od_tgt[s] < od_reg[s]);
            trk_init_q[3+s] = (od_zero[s] == 8'(TR_SPAN[3+s])) ? DEG_ONE : '0;
        end
    end

    for (genvar g = 0; g < TR_N; g++)
    begin : g_trk
        localparam int SPAN2 = 2 * TR_SPAN[g];
        localparam int INC_Q = ONE / TR_SPAN[g];
        localparam int INC_R = (2 * ONE) % SPAN2;

        logic [R_W:0]    r_up, r_dn;
        logic [DEG_W-1:0] q_next;
        logic [R_W-1:0]   r_next;

        always_comb
        begin
            r_up   = {1'b0, trk_r_reg[g]} + (R_W+1)'(INC_R);
            r_dn   = {1'b0, trk_r_reg[g]} + (R_W+1)'(SPAN2 - INC_R);
            q_next = trk_q_reg[g];
            r_next = trk_r_reg[g];
            if (trk_init[g])
            begin
                q_next = trk_init_q[g];
                r_next = R_W'(TR_SPAN[g]);
            end
            else if (trk_up[g])
            begin
                if (r_up >= (R_W+1)'(SPAN2))
                begin
                    r_next = R_W'(r_up - (R_W+1)'(SPAN2));
                    q_next = trk_q_reg[g] + DEG_W'(INC_Q + 1);
                end
                else
                begin
                    r_next = r_up[R_W-1:0];
                    q_next = trk_q_reg[g] + DEG_W'(INC_Q);
                end
            end
            else if (trk_dn[g])
            begin
                // borrow from the quotient when the remainder runs under
                if (trk_r_reg[g] < R_W'(INC_R))
                begin
                    r_next = r_dn[R_W-1:0];
                    q_next = trk_q_reg[g] - DEG_W'(INC_Q + 1);
                end
                else
                begin
                    r_next = R_W'(r_dn - (R_W+1)'(SPAN2));
                    q_next = trk_q_reg[g] - DEG_W'(INC_Q);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            trk_q_reg[g] <= q_next;
            trk_r_reg[g] <= r_next;
        end
    end

    // rule evaluation, one rule per cycle
    assign rule_set = rule_map_reg[{rc_reg, 1'b0} +: 2];
    assign rule_deg = (td_reg[ti_reg] < wd_reg[wj_reg]) ? td_reg[ti_reg] : wd_reg[wj_reg];

    // clipped sets and aggregate at the current speed point
    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            clip[s] = (trk_q_reg[3+s] < str_reg[s]) ? trk_q_reg[3+s] : str_reg[s];
        end
        agg = (clip[0] > clip[1]) ? clip[0] : clip[1];
        agg = (agg > clip[2]) ? agg : clip[2];
        if ((clip[0] >= clip[1]) && (clip[0] >= clip[2]))
            cls = SET_SLOW;
        else if (clip[1] >= clip[2])
            cls = SET_MEDIUM;
        else
            cls = SET_FAST;
    end

    // class of every speed point, read back at the centroid
    ffsi_ram #(
        .WIDTH (2),
        .DEPTH (SPEED_MAX + 1)
    ) u_cls_ram (
        .clk     (clk),
        .wr_en   (state_reg == S_WALK),
        .wr_addr (x_reg),
        .wr_data (cls),
        .rd_addr (quo_reg[Q_W-1:4]),
        .rd_data (cls_rd)
    );

    // restoring divider, one numerator bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[DIVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign rem_ge  = (rem_sh >= {1'b0, den_reg});

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (sample_acc)
                    state_next = S_FUZZ;
            S_FUZZ:
                if (k_reg == FUZZ_LAST)
                    state_next = S_RULE;
            S_RULE:
                if (rc_reg == 4'(RULE_N - 1))
                    state_next = S_WALK;
            S_WALK:
                if (x_reg == X_LAST)
                    state_next = S_DRAIN;
            S_DRAIN:
                if (!v1_reg && !v2_reg)
                    state_next = (den_reg == '0) ? S_CLS : S_DIV;
            S_DIV:
                if (dc_reg == DIV_LAST)
                    state_next = S_RD;
            S_RD:
                state_next = S_CLS;
            S_CLS:
                if (res_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            rc_reg    <= '0;
            ti_reg    <= '0;
            wj_reg    <= '0;
            x_reg     <= '0;
            dc_reg    <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == S_WALK);
            v2_reg    <= v1_reg;

            if (state_reg == S_FUZZ)
                k_reg <= k_reg + 5'd1;
            else
                k_reg <= '0;

            if (state_reg == S_RULE)
            begin
                rc_reg <= rc_reg + 4'd1;
                if (wj_reg == 2'd2)
                begin
                    wj_reg <= '0;
                    ti_reg <= ti_reg + 2'd1;
                end
                else
                begin
                    wj_reg <= wj_reg + 2'd1;
                end
            end
            else
            begin
                rc_reg <= '0;
                ti_reg <= '0;
                wj_reg <= '0;
            end

            if (state_reg == S_WALK)
                x_reg <= x_reg + X_W'(1);
            else
                x_reg <= '0;

            if (state_reg == S_DIV)
                dc_reg <= dc_reg + DC_W'(1);
            else
                dc_reg <= '0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            t_reg <= (temperature > TEMP_SAT) ? TEMP_SAT : temperature;
            w_reg <= (weather > WEATHER_SAT) ? WEATHER_SAT : weather;
            for (int s = 0; s < 3; s++)
            begin
                str_reg[s] <= '0;
            end
            num_reg <= '0;
            den_reg <= '0;
        end

        // capture each degree as the sweep passes its distance
        if (state_reg == S_FUZZ)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (k_reg == dt[i])
                    td_reg[i] <= trk_q_reg[1];
            end
            if (k_reg == dw[0])
                wd_reg[0] <= trk_q_reg[2];
            if (k_reg == dw[1])
                wd_reg[1] <= trk_q_reg[0];
            if (k_reg == dw[2])
                wd_reg[2] <= trk_q_reg[1];
        end

        if ((state_reg == S_RULE) && (rule_set != SET_NONE))
        begin
            if (rule_deg > str_reg[rule_set])
                str_reg[rule_set] <= rule_deg;
        end

        for (int s = 0; s < 3; s++)
        begin
            if (state_reg == S_WALK)
                od_reg[s] <= od_tgt[s];
            else
                od_reg[s] <= od_zero[s];
        end

        // weighted sum pipeline
        agg1_reg <= agg;
        xa_reg   <= x_reg;
        prod_reg <= xa_reg * agg1_reg;
        agg2_reg <= agg1_reg;
        if (v2_reg)
        begin
            num_reg <= num_reg + NUM_W'(prod_reg);
            den_reg <= den_reg + DEN_W'(agg2_reg);
        end

        if ((state_reg == S_DRAIN) && !v1_reg && !v2_reg)
        begin
            dvd_reg      <= {num_reg, 4'd0};
            rem_reg      <= '0;
            quo_reg      <= '0;
            den_zero_reg <= (den_reg == '0);
        end
        else if (state_reg == S_DIV)
        begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[Q_W-2:0], rem_ge};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if ((state_reg == S_CLS) && res_free)
        begin
            result_valid <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CLS) && res_free)
        begin
            if (den_zero_reg)
            begin
                speed_integer  <= '0;
                speed_fraction <= '0;
                speed_class    <= SET_SLOW;
                no_output      <= 1'b1;
            end
            else
            begin
                speed_integer  <= quo_reg[Q_W-1:4];
                speed_fraction <= quo_reg[3:0];
                speed_class    <= cls_rd;
                no_output      <= 1'b0;
            end
        end
    end

    // checks
    a_empty_curve_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_output |->
            (speed_integer == '0) && (speed_fraction == '0) && (speed_class == SET_SLOW))
        else $error("empty curve gave a non-zero speed");

    a_class_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (speed_class != SET_NONE))
        else $error("speed class out of range");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (speed_integer <= X_LAST))
        else $error("centroid above the top speed");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("division started on a zero denominator");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLS) && res_free |=> result_valid && sample_ready)
        else $error("finished item not handed to the output register");

endmodule
